// ----- src/aes128_block_decrypt_top_defines.svh -----
// ---------------------------------------------------------------------------
// aes128_block_decrypt_top_defines.svh
// Assertion macros shared by the AES-128 decryption block.
// ---------------------------------------------------------------------------
`ifndef AES128_BLOCK_DECRYPT_TOP_DEFINES_SVH
`define AES128_BLOCK_DECRYPT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define AESD_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aesd assertion failed");

// antecedent implies consequent in the next cycle
`define AESD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aesd assertion failed");

`else

`define AESD_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define AESD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- src/aesd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aesd_pkg
// Types, S-box tables and GF(2^8) helpers for the AES-128 decryption block.
// ---------------------------------------------------------------------------
package aesd_pkg;

   typedef logic [7:0] byte_table_type [256];

   // csr write request, decoded by register
   typedef struct packed {
      logic        wr_key_high;
      logic        wr_key_low;
      logic [63:0] data;
   } cfg_write_type;

   localparam logic [3:0] ADDR_KEY_HIGH = 4'h0;
   localparam logic [3:0] ADDR_KEY_LOW  = 4'h8;

   localparam byte_table_type SBOX = '{
      8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
      8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
      8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
      8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
      8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
      8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
      8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
      8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
      8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
      8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
      8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
      8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
      8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
      8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
      8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
      8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
      8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
      8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
      8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
      8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
      8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
      8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
      8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
      8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
      8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
      8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
      8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
      8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
      8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
      8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
      8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
      8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
   };

   // inverse table, built at elaboration
   function automatic byte_table_type build_inv_sbox();
      byte_table_type t;
      for (int i = 0; i < 256; i++) begin
         t[SBOX[i]] = i[7:0];
      end
      return t;
   endfunction

   localparam byte_table_type INV_SBOX = build_inv_sbox();

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // inverse mix column coefficient: sel 0..3 -> 14, 11, 13, 9
   function automatic logic [7:0] gf_inv_coef(input logic [7:0] a, input logic [1:0] sel);
      logic [7:0] a2;
      logic [7:0] a4;
      logic [7:0] a8;
      logic [7:0] r;
      a2 = xtime(a);
      a4 = xtime(a2);
      a8 = xtime(a4);
      case (sel)
         2'd0:    r = a8 ^ a4 ^ a2;
         2'd1:    r = a8 ^ a2 ^ a;
         2'd2:    r = a8 ^ a4 ^ a;
         default: r = a8 ^ a;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/aes128_block_decrypt_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aes128_block_decrypt_top
// AES-128 inverse cipher as a chain of registered round cells.
// ---------------------------------------------------------------------------
// The start transfer edge loads the initial key add into a register, then
// each round cell registers the block in turn until rsp_valid is high.
// Throughput: one block per cycle while busy is low; each cell holds one
// block in flight. Key expansion runs after reset and after each key write,
// one round key per cycle; busy is high meanwhile (and in reset).
// Reset clears the key to zero; results are never stalled by the receiver.
// ---------------------------------------------------------------------------
`include "aes128_block_decrypt_top_defines.svh"
module aes128_block_decrypt_top
   import aesd_pkg::*;
#(
   parameter int ROUND_COUNT = 10
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   // result channel
   output logic             rsp_valid,
   output logic [63:0]      rsp_plain_high,
   output logic [63:0]      rsp_plain_low,
   // csr port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [63:0] pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);

   logic          accept;
   logic          sched_busy;
   logic          csr_write;
   cfg_write_type cfg_wr;
   logic [63:0]   key_high;
   logic [63:0]   key_low;
   logic [127:0]  round_keys [ROUND_COUNT+1];

   // stage 0 holds the block after the initial key add
   logic          stage_valid [ROUND_COUNT+1];
   logic [127:0]  stage_state [ROUND_COUNT+1];
   logic          init_valid_ff;
   logic [127:0]  init_state_ff;

   // csr: always ready, writes land on the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign cfg_wr.wr_key_high = csr_write && (paddr == ADDR_KEY_HIGH);
   assign cfg_wr.wr_key_low  = csr_write && (paddr == ADDR_KEY_LOW);
   assign cfg_wr.data        = pwdata;

   always_comb begin
      case (paddr)
         ADDR_KEY_HIGH: prdata = key_high;
         ADDR_KEY_LOW:  prdata = key_low;
         default:       prdata = '0;
      endcase
   end

   aesd_key_sched #(
      .ROUND_COUNT(ROUND_COUNT)
   ) u_key_sched (
      .clock      (clock),
      .reset      (reset),
      .cfg_wr     (cfg_wr),
      .key_high   (key_high),
      .key_low    (key_low),
      .round_keys (round_keys),
      .busy       (sched_busy)
   );

   // no transfer while round keys are being rebuilt
   assign busy   = sched_busy || reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_valid_ff <= 1'b0;
      end else begin
         init_valid_ff <= accept;
      end
   end

   // initial add of the last round key
   always_ff @(posedge clock) begin
      init_state_ff <= {req_block_high, req_block_low} ^ round_keys[ROUND_COUNT];
   end

   assign stage_valid[0] = init_valid_ff;
   assign stage_state[0] = init_state_ff;

   // cell j applies round key ROUND_COUNT-j; the last cell skips mix columns
   for (genvar j = 1; j <= ROUND_COUNT; j++) begin : g_cell
      aesd_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[j-1]),
         .in_state  (stage_state[j-1]),
         .round_key (round_keys[ROUND_COUNT-j]),
         .skip_mix  (j == ROUND_COUNT),
         .out_valid (stage_valid[j]),
         .out_state (stage_state[j])
      );
   end

   assign rsp_valid      = stage_valid[ROUND_COUNT];
   assign rsp_plain_high = stage_state[ROUND_COUNT][127:64];
   assign rsp_plain_low  = stage_state[ROUND_COUNT][63:0];

   `AESD_ASSERT_NEXT(a_accept_enters, clock, reset, accept, stage_valid[0])
   `AESD_ASSERT_SAME(a_no_accept_busy, clock, reset, sched_busy, !accept)

endmodule
`default_nettype wire

// ----- src/aesd_key_sched.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aesd_key_sched
// Key registers and round key expansion, one round key per cycle.
// ---------------------------------------------------------------------------
`include "aes128_block_decrypt_top_defines.svh"
module aesd_key_sched
   import aesd_pkg::*;
#(
   parameter int ROUND_COUNT = 10
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_write_type cfg_wr,
   output logic [63:0]        key_high,
   output logic [63:0]        key_low,
   output logic [127:0]       round_keys [ROUND_COUNT+1],
   output logic               busy
);

   localparam int IDX_W = $clog2(ROUND_COUNT + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUND_COUNT);

   logic [63:0]      key_high_ff;
   logic [63:0]      key_low_ff;
   logic [127:0]     rk_ff [ROUND_COUNT+1];
   logic [127:0]     work_ff;
   logic [127:0]     work_in;
   logic [7:0]       rcon_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             busy_ff;
   logic [31:0]      temp;
   logic [31:0]      w0, w1, w2, w3;

   always_comb begin
      temp = {SBOX[work_ff[23:16]] ^ rcon_ff, SBOX[work_ff[15:8]],
              SBOX[work_ff[7:0]], SBOX[work_ff[31:24]]};
      w0 = work_ff[127:96] ^ temp;
      w1 = work_ff[95:64] ^ w0;
      w2 = work_ff[63:32] ^ w1;
      w3 = work_ff[31:0] ^ w2;
      work_in = (idx_ff == '0) ? {key_high_ff, key_low_ff} : {w0, w1, w2, w3};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         idx_ff      <= '0;
         busy_ff     <= 1'b1;
         rcon_ff     <= 8'h01;
      end else if (cfg_wr.wr_key_high || cfg_wr.wr_key_low) begin
         if (cfg_wr.wr_key_high) begin
            key_high_ff <= cfg_wr.data;
         end
         if (cfg_wr.wr_key_low) begin
            key_low_ff <= cfg_wr.data;
         end
         idx_ff  <= '0;
         busy_ff <= 1'b1;
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         if (idx_ff != '0) begin
            rcon_ff <= xtime(rcon_ff);
         end
         if (idx_ff == LAST_IDX) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         work_ff        <= work_in;
         rk_ff[idx_ff]  <= work_in;
      end
   end

   assign key_high   = key_high_ff;
   assign key_low    = key_low_ff;
   assign round_keys = rk_ff;
   assign busy       = busy_ff;

   `AESD_ASSERT_SAME(a_idx_range, clock, reset, busy_ff, idx_ff <= LAST_IDX)
   `AESD_ASSERT_NEXT(a_idle_holds, clock, reset,
      !busy_ff && !cfg_wr.wr_key_high && !cfg_wr.wr_key_low, !busy_ff)

endmodule
`default_nettype wire

// ----- src/aesd_round_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// aesd_round_cell
// One registered inverse round: shift rows, S-box, add key, then mix columns unless skip_mix is set.
// ---------------------------------------------------------------------------
module aesd_round_cell
   import aesd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire logic [127:0] in_state,
   input  wire logic [127:0] round_key,
   input  wire logic         skip_mix,
   output logic              out_valid,
   output logic [127:0]      out_state
);

   logic         valid_ff;
   logic [127:0] state_ff;
   logic [127:0] keyed;
   logic [127:0] mixed;
   logic [127:0] state_in;

   always_comb begin
      logic [7:0] acc;
      // byte i at row i%4, column i/4
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            keyed[127-8*(r+4*c) -: 8] =
               INV_SBOX[in_state[127-8*(r+4*((c-r+4)%4)) -: 8]]
               ^ round_key[127-8*(r+4*c) -: 8];
         end
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               acc = acc ^ gf_inv_coef(keyed[127-8*(k+4*c) -: 8], 2'((k-r+4)%4));
            end
            mixed[127-8*(r+4*c) -: 8] = acc;
         end
      end
      state_in = skip_mix ? keyed : mixed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the AES-128 decryption block: random and directed
// ciphertext under several keys, each plaintext checked against a local
// model of the inverse cipher.
// ---------------------------------------------------------------------------

// in-order store of predicted plaintexts, checked as results arrive
class plain_board;
   logic [63:0] exp_hi_q[$];
   logic [63:0] exp_lo_q[$];
   int          mismatches;

   function void note_block(input logic [63:0] hi, input logic [63:0] lo);
      exp_hi_q.push_back(hi);
      exp_lo_q.push_back(lo);
   endfunction

   function void check_plain(input logic [63:0] hi, input logic [63:0] lo);
      logic [63:0] eh;
      logic [63:0] el;
      if (exp_hi_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h %h", hi, lo);
         return;
      end
      eh = exp_hi_q.pop_front();
      el = exp_lo_q.pop_front();
      if (eh !== hi || el !== lo) begin
         mismatches++;
         if (mismatches <= 10)
            $display("plain mismatch: exp %h %h got %h %h", eh, el, hi, lo);
      end
   endfunction

   function int pending();
      return exp_hi_q.size();
   endfunction
endclass

module tb;
   import aesd_pkg::*;

   localparam int LATENCY   = 11;
   localparam int WD_LIMIT  = 2000;
   localparam int N_RANDOM  = 830;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_block_high = '0;
   logic [63:0] req_block_low  = '0;
   logic        rsp_valid;
   logic [63:0] rsp_plain_high;
   logic [63:0] rsp_plain_low;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   // model copy of the key registers
   logic [63:0] key_hi_m;
   logic [63:0] key_lo_m;
   logic [7:0]  fwd_tab[256];
   logic [7:0]  inv_tab[256];

   plain_board board;
   int         idle_cycles;

   aes128_block_decrypt_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_block_high(req_block_high), .req_block_low(req_block_low),
      .rsp_valid(rsp_valid), .rsp_plain_high(rsp_plain_high),
      .rsp_plain_low(rsp_plain_low), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   // ---- GF(2^8) arithmetic, written independently of the package helpers
   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int k = 0; k < 8; k++) begin
         if (b[k]) acc ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      end
      return acc;
   endfunction

   // S-box from the field inverse plus affine map
   function automatic void build_tables();
      logic [7:0] inv;
      logic [7:0] s;
      for (int x = 0; x < 256; x++) begin
         inv = 8'h00;
         if (x != 0) begin
            inv = 8'h01;
            for (int e = 0; e < 254; e++) inv = gmul(inv, x[7:0]);
         end
         s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         fwd_tab[x] = s;
         inv_tab[s] = x[7:0];
      end
   endfunction

   // full inverse cipher under the modeled key
   function automatic logic [127:0] decrypt_block(input logic [63:0] hi,
                                                  input logic [63:0] lo);
      logic [7:0] rk[176];
      logic [7:0] st[16];
      logic [7:0] t[16];
      logic [7:0] w[4];
      logic [7:0] f;
      logic [7:0] rc;
      logic [7:0] acc;
      logic [7:0] cf[4];
      logic [127:0] res;
      cf = '{8'd14, 8'd11, 8'd13, 8'd9};
      rc = 8'h01;
      for (int i = 0; i < 8; i++) begin
         rk[i]     = key_hi_m[63-8*i -: 8];
         rk[8 + i] = key_lo_m[63-8*i -: 8];
         st[i]     = hi[63-8*i -: 8];
         st[8 + i] = lo[63-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if (i % 4 == 0) begin
            f = w[0];
            w[0] = fwd_tab[w[1]] ^ rc;
            w[1] = fwd_tab[w[2]];
            w[2] = fwd_tab[w[3]];
            w[3] = fwd_tab[f];
            rc = gmul(rc, 8'h02);
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[160 + i];
      for (int rnd = 9; rnd >= 0; rnd--) begin
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r + 4*c] = inv_tab[st[r + 4*((c - r + 4) & 3)]];
         for (int i = 0; i < 16; i++) st[i] = t[i] ^ rk[16*rnd + i];
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  acc = 8'h00;
                  for (int k = 0; k < 4; k++)
                     acc ^= gmul(st[4*c+k], cf[(k - r + 4) & 3]);
                  t[4*c + r] = acc;
               end
            st = t;
         end
      end
      for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
      return res;
   endfunction

   // ---- bus and command drivers
   task automatic csr_write(input logic [3:0] addr, input logic [63:0] data);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr == ADDR_KEY_HIGH) key_hi_m = data;
      else if (addr == ADDR_KEY_LOW) key_lo_m = data;
   endtask

   // one transfer: hold start until the block takes it, then note the prediction
   task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                             input bit keep);
      logic [127:0] p;
      start <= 1'b1;
      req_block_high <= hi;
      req_block_low <= lo;
      do @(posedge clock); while (busy);
      p = decrypt_block(hi, lo);
      board.note_block(p[127:64], p[63:0]);
      if (!keep) start <= 1'b0;
   endtask

   // lets the pipeline drain; key writes only happen with nothing in flight
   task automatic drain();
      while (board.pending() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // random field value, biased toward all-zeros/all-ones and single bits
   function automatic logic [63:0] pick64();
      case ($urandom_range(0, 9))
         0:       return 64'h0;
         1:       return '1;
         2:       return 64'h1 << $urandom_range(0, 63);
         default: return rand64();
      endcase
   endfunction

   // start stays high across a burst end when no gap follows
   task automatic random_phase(input int count);
      int burst;
      int gap;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 15) : 0;
         for (int b = 0; b < burst && sent < count; b++) begin
            send_block(pick64(), pick64(),
                       (b != burst - 1 || gap == 0) && sent != count - 1);
            sent++;
         end
         if (gap != 0)
            repeat (gap) @(posedge clock);
      end
   endtask

   // result monitor: every strobe is a transfer the bench must take
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_plain(rsp_plain_high, rsp_plain_low);
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
         $display("aes128_block_decrypt_top regression: fail");
         $finish;
      end
   end

   initial begin
      logic [63:0] kh[5];
      logic [63:0] kl[5];
      board = new();
      idle_cycles = 0;
      key_hi_m = '0;
      key_lo_m = '0;
      build_tables();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset key, field extremes, then the standard test vector and random blocks under its key
      send_block(64'h0, 64'h0, 1'b1);
      send_block('1, '1, 1'b1);
      send_block(64'h8000_0000_0000_0000, 64'h1, 1'b1);
      send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      drain();
      csr_write(ADDR_KEY_HIGH, 64'h0001_0203_0405_0607);
      csr_write(ADDR_KEY_LOW, 64'h0809_0a0b_0c0d_0e0f);
      send_block(64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a, 1'b1);
      for (int i = 0; i < 8; i++) send_block(pick64(), pick64(), i != 7);
      drain();

      // key sweep: extremes, the standard key with its test vector, and random keys
      kh = '{64'h0, '1, 64'h2b7e_1516_28ae_d2a6, rand64(), rand64()};
      kl = '{'1, 64'h0, 64'habf7_1588_09cf_4f3c, rand64(), rand64()};
      for (int k = 0; k < 5; k++) begin
         csr_write(ADDR_KEY_HIGH, kh[k]);
         csr_write(ADDR_KEY_LOW, kl[k]);
         if (k == 2) send_block(64'h3925_841d_02dc_09fb, 64'hdc11_8597_196a_0b32, 1'b1);
         random_phase(N_RANDOM / 5);
         drain();
      end

      if (board.mismatches == 0 && board.pending() == 0)
         $display("aes128_block_decrypt_top regression: pass");
      else
         $display("aes128_block_decrypt_top regression: fail");
      $finish;
   end
endmodule
